// ===== rtl/sst_pkg.sv =====
package sst_pkg;

    localparam int TEXT_DEPTH = 32;
    localparam int NUM_DIGITS = 8;

    localparam int POS_W = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int DIG_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_RESTART = 2'd2
    } t_op;

    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_DASH = 8'h2D;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [7:0] DIGIT_GLYPHS [10] = '{
        8'b01101111, 8'b00001100, 8'b01110101, 8'b01011101, 8'b00011110,
        8'b01011011, 8'b01111011, 8'b00001101, 8'b01111111, 8'b00011111
    };
    localparam logic [7:0] GLYPH_DASH  = 8'b00010000;
    localparam logic [7:0] GLYPH_DOT   = 8'b10000000;
    localparam logic [7:0] GLYPH_BLANK = 8'b00000000;

    typedef struct packed {
        logic [1:0] operation;
        logic [4:0] write_index;
        logic [7:0] write_char;
    } t_req;

    typedef struct packed {
        logic [7:0] segments;
        logic [7:0] digit_select;
    } t_res;

    // Write port of the text store
    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] addr;
        logic [7:0]       data;
    } t_wr;

    // Scan commands for the current cycle
    typedef struct packed {
        logic tick;
        logic restart;
    } t_scan_cmd;

    function automatic logic [7:0] glyph_of(input logic [7:0] ch);
        logic [7:0] g;
        g = GLYPH_BLANK;
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            g = DIGIT_GLYPHS[4'(ch - CHAR_ZERO)];
        end else if (ch == CHAR_DASH) begin
            g = GLYPH_DASH;
        end
        return g;
    endfunction

endpackage

// ===== rtl/sst_store.sv =====
module sst_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sst_pkg::t_wr              i_wr,
    input  logic [sst_pkg::POS_W-1:0] i_rd_pos,
    output logic [7:0]                o_cur,
    output logic [7:0]                o_nxt
);

    logic [7:0]                  mem [sst_pkg::TEXT_DEPTH];
    logic [sst_pkg::TEXT_DEPTH-1:0] r_valid;
    logic [7:0]                  r_cur;
    logic [7:0]                  r_nxt;

    logic [sst_pkg::POS_W:0]     nxt_wide;
    logic                        nxt_in_range;
    logic [sst_pkg::POS_W-1:0]   nxt_addr;
    logic [7:0]                  n_cur;
    logic [7:0]                  n_nxt;

    assign nxt_wide     = {1'b0, i_rd_pos} + {{sst_pkg::POS_W{1'b0}}, 1'b1};
    assign nxt_in_range = (nxt_wide < (sst_pkg::POS_W + 1)'(sst_pkg::TEXT_DEPTH));
    assign nxt_addr     = nxt_wide[sst_pkg::POS_W-1:0];

    // Read with write-first bypass; an entry never written reads as NUL
    always_comb begin
        if (i_wr.en && i_wr.addr == i_rd_pos) begin
            n_cur = i_wr.data;
        end else if (r_valid[i_rd_pos]) begin
            n_cur = mem[i_rd_pos];
        end else begin
            n_cur = sst_pkg::CHAR_NUL;
        end

        if (!nxt_in_range) begin
            n_nxt = sst_pkg::CHAR_NUL;
        end else if (i_wr.en && i_wr.addr == nxt_addr) begin
            n_nxt = i_wr.data;
        end else if (r_valid[nxt_addr]) begin
            n_nxt = mem[nxt_addr];
        end else begin
            n_nxt = sst_pkg::CHAR_NUL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_cur   <= sst_pkg::CHAR_NUL;
            r_nxt   <= sst_pkg::CHAR_NUL;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            r_cur <= n_cur;
            r_nxt <= n_nxt;
        end
    end

    assign o_cur = r_cur;
    assign o_nxt = r_nxt;

endmodule

// ===== rtl/sst_scan.sv =====
module sst_scan (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sst_pkg::t_scan_cmd        i_cmd,
    input  logic [7:0]                i_cur,
    input  logic [7:0]                i_nxt,
    output sst_pkg::t_res             o_res,
    output logic [sst_pkg::POS_W-1:0] o_pos_next
);

    logic [sst_pkg::POS_W-1:0] r_pos;
    logic [sst_pkg::DIG_W-1:0] r_dig;
    logic [sst_pkg::POS_W-1:0] n_pos;
    logic [sst_pkg::DIG_W-1:0] n_dig;

    logic [sst_pkg::POS_W:0]   pos_inc;
    logic                      dot_next;
    logic                      wrap;
    logic [sst_pkg::DIG_W-1:0] dig_adv;
    logic [7:0]                sel;

    assign pos_inc  = {1'b0, r_pos} + {{sst_pkg::POS_W{1'b0}}, 1'b1};
    assign dot_next = (i_nxt == sst_pkg::CHAR_DOT);
    assign wrap     = (pos_inc >= (sst_pkg::POS_W + 1)'(sst_pkg::TEXT_DEPTH))
                   || (i_nxt == sst_pkg::CHAR_NUL);

    always_comb begin
        if (dot_next) begin
            dig_adv = r_dig;
        end else if (r_dig == sst_pkg::DIG_W'(sst_pkg::NUM_DIGITS - 1)) begin
            dig_adv = '0;
        end else begin
            dig_adv = r_dig + sst_pkg::DIG_W'(1);
        end
    end

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            sel[k] = (32'(r_dig) == k);
        end
    end

    always_comb begin
        n_pos = r_pos;
        n_dig = r_dig;
        if (i_cmd.restart) begin
            n_pos = '0;
            n_dig = '0;
        end else if (i_cmd.tick) begin
            if (wrap) begin
                n_pos = '0;
                n_dig = '0;
            end else begin
                n_pos = pos_inc[sst_pkg::POS_W-1:0];
                n_dig = dig_adv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_dig <= '0;
        end else begin
            r_pos <= n_pos;
            r_dig <= n_dig;
        end
    end

    assign o_res.segments     = sst_pkg::glyph_of(i_cur)
                              | (dot_next ? sst_pkg::GLYPH_DOT : sst_pkg::GLYPH_BLANK);
    assign o_res.digit_select = sel;
    assign o_pos_next         = n_pos;

endmodule

// ===== rtl/seven_segment_text_scanner_top.sv =====
// Seven-segment text scanner: shows a stored string on a multiplexed row of
// digits, one digit per tick request.
//
// Input channel (i_in_valid / o_in_ready / i_in_req): each request is a tick,
// a character write into the text store, or a scan restart. Writes and
// restarts produce no result; a tick produces one result with the segment
// pattern (bit 7 is the dot) and the one-hot digit enable.
// Output channel (o_out_valid / i_out_ready / o_out_res).
//
// A tick accepted into the input register has its result loaded into the
// result register when it executes. Throughput: one request per cycle while no
// tick is held back by a full output; the characters at the scan position and
// the one after it are prefetched into registers from the text store's two
// synchronous read ports, so each tick needs only a glyph lookup and a counter update.
// A tick request waits in the input register while the output register is
// full and not being taken; ready then drops until the receiver takes the
// result. Writes and restarts retire even while the output register is full.
// Reset clears the text store to NUL (per-entry valid bits, no clearing pass),
// the scan position and digit index, and both pipeline registers.
module seven_segment_text_scanner_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sst_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sst_pkg::t_res o_out_res
);

    // Input register
    logic          r_in_valid;
    sst_pkg::t_req r_in_req;

    // Result register
    logic          r_out_valid;
    sst_pkg::t_res r_out_res;

    logic               out_free;
    logic               is_tick;
    logic               is_write;
    logic               is_restart;
    logic               exec;
    sst_pkg::t_wr       wr;
    sst_pkg::t_scan_cmd cmd;
    sst_pkg::t_res      res;
    logic [sst_pkg::POS_W-1:0] pos_next;
    logic [7:0]         cur_char;
    logic [7:0]         nxt_char;

    assign is_tick    = (r_in_req.operation == sst_pkg::OP_TICK);
    assign is_write   = (r_in_req.operation == sst_pkg::OP_WRITE);
    assign is_restart = (r_in_req.operation == sst_pkg::OP_RESTART);

    // Only a tick needs a free result slot; other requests retire at once
    assign out_free   = !r_out_valid || i_out_ready;
    assign exec       = r_in_valid && (!is_tick || out_free);
    assign o_in_ready = !r_in_valid || exec;

    // Drop writes beyond the end of the store
    assign wr.en   = exec && is_write
                  && (32'(r_in_req.write_index) < 32'(sst_pkg::TEXT_DEPTH));
    assign wr.addr = sst_pkg::POS_W'(r_in_req.write_index);
    assign wr.data = r_in_req.write_char;

    assign cmd.tick    = exec && is_tick;
    assign cmd.restart = exec && is_restart;

    sst_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (wr),
        .i_rd_pos (pos_next),
        .o_cur    (cur_char),
        .o_nxt    (nxt_char)
    );

    sst_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cur      (cur_char),
        .i_nxt      (nxt_char),
        .o_res      (res),
        .o_pos_next (pos_next)
    );

    // Hold the request until it executes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_req <= i_in_req;
        end
    end

    // Load the result on a tick, clear it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.tick) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.tick) begin
            r_out_res <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

`ifndef SYNTHESIS
    // At most one digit is driven per result
    a_sel_onehot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(o_out_res.digit_select))
        else $error("digit_select not one-hot");

    // An executed tick always presents a result next cycle
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.tick |=> o_out_valid)
        else $error("tick executed without result");

    // Ready drops only while a request is held and blocked by a full output
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && is_tick && r_out_valid && !i_out_ready))
        else $error("input stalled without cause");

    // Write and scan commands never fire together
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({wr.en, cmd.tick, cmd.restart}) <= 1)
        else $error("more than one command in a cycle");
`endif

endmodule
